[hdl/ordered_list_engine_macros.svh]
// Assertion macros used by the port checker of the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define OLE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered list engine: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define OLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list engine: next-cycle check failed");

`endif

[hdl/ole_pkg.sv]
// Types and constants of the ordered list engine.
package ole_pkg;

  // Field widths
  localparam int OPC_W  = 3;
  localparam int POS_W  = 9;
  localparam int DATA_W = 32;
  localparam int STS_W  = 2;
  localparam int CNT9_W = 9;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Opcodes
  localparam logic [OPC_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OPC_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OPC_W-1:0] OP_GET    = 3'd2;
  localparam logic [OPC_W-1:0] OP_PRED   = 3'd3;
  localparam logic [OPC_W-1:0] OP_SUCC   = 3'd4;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd5;
  // Cell command with no effect on the chain
  localparam logic [OPC_W-1:0] OP_NONE   = 3'd7;

  // Status codes
  localparam logic [STS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL = 2'd2;

  // Command broadcast to every cell during a sweep
  typedef struct packed {
    logic [OPC_W-1:0]  op;
    logic [DATA_W-1:0] key;
  } cmd_t;

  // Token that walks the chain one cell per cycle
  typedef struct packed {
    logic              active;
    logic              found;
    logic              ok;
    logic [DATA_W-1:0] result;
    logic [DATA_W-1:0] carry;
  } tok_t;

endpackage

[hdl/ole_cell.sv]
// One list cell: holds one entry and acts on the token as it passes.
module ole_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ole_pkg::cmd_t              cmd,
  input  logic [PW-1:0]              start,
  input  logic [PW-1:0]              len,
  input  logic [ole_pkg::DATA_W-1:0] left_val,
  input  logic [ole_pkg::DATA_W-1:0] right_val,
  input  ole_pkg::tok_t              tok_in,
  output ole_pkg::tok_t              tok_out,
  output logic [ole_pkg::DATA_W-1:0] store_val
);

  localparam logic [PW-1:0] IDX      = PW'(INDEX);
  localparam logic [PW-1:0] IDX_NEXT = PW'(INDEX + 1);

  logic [ole_pkg::DATA_W-1:0] store;
  logic [ole_pkg::DATA_W-1:0] store_next;
  ole_pkg::tok_t              tok_next;
  logic                       match;

  assign store_val = store;

  // First-match test for predecessor and successor searches
  assign match = tok_in.active && !tok_in.found && (IDX < len) && (store == cmd.key);

  // Cell action while the token sits here
  always_comb begin
    tok_next   = tok_in;
    store_next = store;
    if (tok_in.active) begin
      case (cmd.op)
        ole_pkg::OP_INSERT: begin
          if (IDX >= start) begin
            store_next    = (IDX == start) ? cmd.key : tok_in.carry;
            tok_next.carry = store;
          end
        end
        ole_pkg::OP_DELETE: begin
          if (IDX >= start) begin
            store_next = right_val;
          end
          if (IDX == start) begin
            tok_next.result = store;
            tok_next.ok     = 1'b1;
          end
        end
        ole_pkg::OP_GET: begin
          if (IDX == start) begin
            tok_next.result = store;
            tok_next.ok     = 1'b1;
          end
        end
        ole_pkg::OP_PRED: begin
          tok_next.found = tok_in.found | match;
          if (match && (IDX != '0)) begin
            tok_next.result = left_val;
            tok_next.ok     = 1'b1;
          end
        end
        ole_pkg::OP_SUCC: begin
          tok_next.found = tok_in.found | match;
          if (match && (IDX_NEXT < len)) begin
            tok_next.result = right_val;
            tok_next.ok     = 1'b1;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    store <= store_next;
  end

  // Token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

[hdl/ole_ctrl.sv]
// Control: stream handshakes, length, position checks, sweep launch and result.
module ole_ctrl #(
  parameter int CAPACITY = 256,
  parameter int PW       = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ole_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata,
  output ole_pkg::cmd_t                  cmd,
  output logic [PW-1:0]                  start,
  output logic [PW-1:0]                  len,
  output ole_pkg::tok_t                  tok_launch,
  input  ole_pkg::tok_t                  tok_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BUSY  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                     state;
  logic [CNT_W-1:0]               length;
  logic [CNT_W-1:0]               length_next;
  logic                           launch;
  logic [ole_pkg::STS_W-1:0]      pre_status;
  logic [ole_pkg::STS_W-1:0]      status_next;
  logic                           use_chain;
  logic                           use_chain_next;
  logic [ole_pkg::OPC_W-1:0]      op_next;
  logic [ole_pkg::DATA_W-1:0]     pend_result;
  logic                           pend_ok;
  logic [ole_pkg::STS_W-1:0]      fin_status;
  logic [PW+ole_pkg::CNT9_W-1:0]  cnt_wide;
  logic                           out_load;

  // Input fields
  logic [ole_pkg::OPC_W-1:0]  in_opcode;
  logic [ole_pkg::POS_W-1:0]  in_position;
  logic [ole_pkg::DATA_W-1:0] in_value;
  logic [PW-1:0]              pos_x;
  logic                       full;
  logic                       ins_pos_ok;
  logic                       rd_pos_ok;

  assign in_opcode   = s_tdata[2:0];
  assign in_position = s_tdata[11:3];
  assign in_value    = s_tdata[43:12];

  assign s_tready = (state == S_IDLE);
  assign len      = PW'(length);
  assign pos_x    = PW'(in_position);
  assign full     = (len == PW'(CAPACITY));
  assign ins_pos_ok = (pos_x != '0) && (pos_x <= len + PW'(1));
  assign rd_pos_ok  = (pos_x != '0) && (pos_x <= len);

  assign tok_launch = '{active: launch, found: 1'b0, ok: 1'b0,
                        result: '0, carry: '0};

  // Decode of an incoming transaction
  always_comb begin
    op_next        = ole_pkg::OP_NONE;
    status_next    = ole_pkg::ST_MISS;
    use_chain_next = 1'b0;
    length_next    = length;
    unique case (in_opcode)
      ole_pkg::OP_INSERT: begin
        if (ins_pos_ok) begin
          if (full) begin
            status_next = ole_pkg::ST_FULL;
          end else begin
            status_next = ole_pkg::ST_OK;
            op_next     = ole_pkg::OP_INSERT;
            length_next = length + CNT_W'(1);
          end
        end
      end
      ole_pkg::OP_DELETE: begin
        if (rd_pos_ok) begin
          status_next = ole_pkg::ST_OK;
          op_next     = ole_pkg::OP_DELETE;
          length_next = length - CNT_W'(1);
        end
      end
      ole_pkg::OP_GET: begin
        if (rd_pos_ok) begin
          status_next = ole_pkg::ST_OK;
          op_next     = ole_pkg::OP_GET;
        end
      end
      ole_pkg::OP_PRED: begin
        op_next        = ole_pkg::OP_PRED;
        use_chain_next = 1'b1;
      end
      ole_pkg::OP_SUCC: begin
        op_next        = ole_pkg::OP_SUCC;
        use_chain_next = 1'b1;
      end
      ole_pkg::OP_CLEAR: begin
        status_next = ole_pkg::ST_OK;
        length_next = '0;
      end
      default: begin
        status_next = ole_pkg::ST_MISS;
      end
    endcase
  end

  assign out_load = (state == S_DRAIN) && (!m_tvalid || m_tready);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      length   <= '0;
      launch   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Launch pulse in the cycle after an accepted transaction
      launch <= (state == S_IDLE) && s_tvalid;
      // Result register: set on load, cleared once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            length <= length_next;
            state  <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (tok_last.active) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Final status and count
  assign fin_status = use_chain ? (pend_ok ? ole_pkg::ST_OK : ole_pkg::ST_MISS) : pre_status;
  assign cnt_wide   = (PW + ole_pkg::CNT9_W)'(length);

  // Command, pending result and output payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd.op     <= op_next;
      cmd.key    <= in_value;
      start      <= pos_x - PW'(1);
      pre_status <= status_next;
      use_chain  <= use_chain_next;
    end
    if ((state == S_BUSY) && tok_last.active) begin
      pend_result <= tok_last.result;
      pend_ok     <= tok_last.ok;
    end
    if (out_load) begin
      m_tdata <= {4'd0, (length == '0), cnt_wide[ole_pkg::CNT9_W-1:0],
                  pend_result, fin_status};
    end
  end

endmodule

[hdl/ordered_list_engine.sv]
// Top level of the ordered list engine: control plus a chain of list cells.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | opcode, position, item_value
//  m_*     | out | m_tvalid/m_tready  | status, value_out, element_count, empty
//
// Each transaction launches a token that walks the cell chain one cell per
// cycle; one item is in flight at a time. rst (synchronous) empties the
// list; entry contents are not cleared. A stalled result holds in the
// output register; a new item is accepted while it waits.
module ordered_list_engine #(
  parameter int CAPACITY = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [2:0] opcode, [11:3] position, [43:12] item_value, [47:44] zero
  input  logic [ole_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status, [33:2] value_out, [42:34] element_count, [43] is_empty
  output logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = ((CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W) + 1;

  ole_pkg::cmd_t              cmd;
  logic [PW-1:0]              start;
  logic [PW-1:0]              len;
  ole_pkg::tok_t              toks [CAPACITY+1];
  logic [ole_pkg::DATA_W-1:0] vals [CAPACITY];
  logic [ole_pkg::DATA_W-1:0] left_v [CAPACITY];
  logic [ole_pkg::DATA_W-1:0] right_v [CAPACITY];

  ole_ctrl #(
    .CAPACITY (CAPACITY),
    .PW       (PW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cmd        (cmd),
    .start      (start),
    .len        (len),
    .tok_launch (toks[0]),
    .tok_last   (toks[CAPACITY])
  );

  // Cell chain with neighbor taps
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    if (gi == 0) begin : g_first
      assign left_v[gi] = '0;
    end else begin : g_mid_l
      assign left_v[gi] = vals[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_v[gi] = vals[gi];
    end else begin : g_mid_r
      assign right_v[gi] = vals[gi+1];
    end

    ole_cell #(
      .INDEX (gi),
      .PW    (PW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .start     (start),
      .len       (len),
      .left_val  (left_v[gi]),
      .right_val (right_v[gi]),
      .tok_in    (toks[gi]),
      .tok_out   (toks[gi+1]),
      .store_val (vals[gi])
    );
  end

endmodule

[hdl/ole_checker.sv]
// Port-level checks of the ordered list engine, bound to the top level.
`include "ordered_list_engine_macros.svh"

module ole_port_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [ole_pkg::STS_W-1:0]  sts;
  logic [ole_pkg::DATA_W-1:0] value_out;
  logic [ole_pkg::CNT9_W-1:0] count;
  logic                       empty;

  assign sts       = m_tdata[1:0];
  assign value_out = m_tdata[33:2];
  assign count     = m_tdata[42:34];
  assign empty     = m_tdata[43];

  // A stalled result stays offered
  `OLE_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // One item in flight: no accept right after an accept
  `OLE_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  // Only the defined status codes appear
  `OLE_ASSERT_NOW(a_status_code, clk, rst, m_tvalid, (sts == ole_pkg::ST_OK) || (sts == ole_pkg::ST_MISS) || (sts == ole_pkg::ST_FULL))
  // Failed operations return zero
  `OLE_ASSERT_NOW(a_fail_zero, clk, rst, m_tvalid && (sts != ole_pkg::ST_OK), value_out == '0)
  // An empty list reports a zero count
  `OLE_ASSERT_NOW(a_empty_count, clk, rst, m_tvalid && empty, count == '0)

endmodule

bind ordered_list_engine ole_port_checker u_port_checker (.*);

[test/ole_checker.sv]
// Scoreboard for the ordered list engine: watches both streams, predicts each reply, compares.
module ole_checker #(
  parameter int CAPACITY = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [ole_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                              fail_count,
  output int                              waiting,
  output int                              n_ok,
  output int                              n_miss,
  output int                              n_full,
  output int                              peak_len
);
  timeunit 1ns;
  timeprecision 1ps;

  // One reply of the engine, field by field
  typedef struct packed {
    logic [ole_pkg::STS_W-1:0]  status;
    logic [ole_pkg::DATA_W-1:0] value;
    logic [ole_pkg::CNT9_W-1:0] count;
    logic                       empty;
  } list_reply_t;

  // Shadow copy of the list
  logic [ole_pkg::DATA_W-1:0] entries [0:CAPACITY-1];
  int                         used;
  list_reply_t                reply_q [$];
  list_reply_t                want;
  list_reply_t                got;

  // Apply one operation to the shadow list and return the reply it gives
  function automatic list_reply_t apply_op(input logic [ole_pkg::OPC_W-1:0] op,
                                           input logic [ole_pkg::POS_W-1:0] pos,
                                           input logic [ole_pkg::DATA_W-1:0] key);
    list_reply_t r;
    int          p;
    int          hit;
    p        = int'(pos);
    r.status = ole_pkg::ST_MISS;
    r.value  = '0;
    // first entry equal to key, or used when there is none
    hit = used;
    for (int i = used - 1; i >= 0; i--)
      if (entries[i] == key) hit = i;
    case (op)
      ole_pkg::OP_INSERT: begin
        if (p >= 1 && p <= used + 1) begin
          if (used >= CAPACITY) begin
            r.status = ole_pkg::ST_FULL;
          end else begin
            for (int i = used; i >= p; i--) entries[i] = entries[i-1];
            entries[p-1] = key;
            used++;
            r.status = ole_pkg::ST_OK;
          end
        end
      end
      ole_pkg::OP_DELETE: begin
        if (p >= 1 && p <= used) begin
          r.value = entries[p-1];
          for (int i = p - 1; i + 1 < used; i++) entries[i] = entries[i+1];
          used--;
          r.status = ole_pkg::ST_OK;
        end
      end
      ole_pkg::OP_GET: begin
        if (p >= 1 && p <= used) begin
          r.value  = entries[p-1];
          r.status = ole_pkg::ST_OK;
        end
      end
      ole_pkg::OP_PRED: begin
        if (hit < used && hit >= 1) begin
          r.value  = entries[hit-1];
          r.status = ole_pkg::ST_OK;
        end
      end
      ole_pkg::OP_SUCC: begin
        if (hit + 1 < used) begin
          r.value  = entries[hit+1];
          r.status = ole_pkg::ST_OK;
        end
      end
      ole_pkg::OP_CLEAR: begin
        used     = 0;
        r.status = ole_pkg::ST_OK;
      end
      default: ;
    endcase
    r.count = ole_pkg::CNT9_W'(used);
    r.empty = (used == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ole_pkg::DATA_W-1:0] exp_v,
                             input logic [ole_pkg::DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  // Replies are matched first, so a reply never pairs with a same-edge request
  always @(posedge clk) begin
    if (rst) begin
      used = 0;
      reply_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.value  = m_tdata[33:2];
        got.count  = m_tdata[42:34];
        got.empty  = m_tdata[43];
        if (reply_q.size() == 0) begin
          $error("reply transaction with no operation pending: status %0d value %0d",
                 got.status, $signed(got.value));
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          check_field("status", ole_pkg::DATA_W'(want.status), ole_pkg::DATA_W'(got.status));
          check_field("value_out", want.value, got.value);
          check_field("element_count", ole_pkg::DATA_W'(want.count),
                      ole_pkg::DATA_W'(got.count));
          check_field("is_empty", ole_pkg::DATA_W'(want.empty), ole_pkg::DATA_W'(got.empty));
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_op(s_tdata[2:0], s_tdata[11:3], s_tdata[43:12]);
        reply_q.push_back(want);
        case (want.status)
          ole_pkg::ST_OK:   n_ok++;
          ole_pkg::ST_FULL: n_full++;
          default:          n_miss++;
        endcase
        if (used > peak_len) peak_len = used;
      end
    end
    waiting = reply_q.size();
  end

endmodule

[test/tb_ordered_list_engine.sv]
// Testbench top for the ordered list engine: stimulus, back-pressure and verdict.
module tb_ordered_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPC_W       = ole_pkg::OPC_W;
  localparam int POS_W       = ole_pkg::POS_W;
  localparam int DATA_W      = ole_pkg::DATA_W;
  localparam int CAPACITY    = 256;
  localparam int HOLD_AT     = 150;   // operations sent before the long back-pressure
  localparam int HOLD_CYCLES = 2000;
  localparam logic [OPC_W-1:0] OP_SPARE = 3'd6;  // unused opcode besides OP_NONE
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ole_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata;

  int fail_count, waiting, n_ok, n_miss, n_full, peak_len;
  int src_idle_pct = 26;
  int snk_idle_pct = 46;
  int sent_count   = 0;
  int shadow_len   = 0;   // length as seen by the stimulus, used to aim positions and steer list size
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  ordered_list_engine #(.CAPACITY(CAPACITY)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ole_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .waiting    (waiting),
    .n_ok       (n_ok),
    .n_miss     (n_miss),
    .n_full     (n_full),
    .peak_len   (peak_len)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  // Reply side: random stalls, plus one long hold-off that backs up the input
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offer one operation; returns at the edge that accepts it
  task automatic put_item(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, val, pos, op};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sent_count++;
    case (op)
      ole_pkg::OP_INSERT: begin
        if (pos >= 1 && pos <= shadow_len + 1 && shadow_len < CAPACITY) shadow_len++;
      end
      ole_pkg::OP_DELETE: begin
        if (pos >= 1 && pos <= shadow_len) shadow_len--;
      end
      ole_pkg::OP_CLEAR: shadow_len = 0;
      default: ;
    endcase
  endtask

  // Values mostly from a small set so searches hit and duplicates occur
  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(99) >= 60) return $urandom;
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return VAL_NEG1;
      default: return DATA_W'($urandom_range(9));
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_insert_pos();
    if ($urandom_range(99) < 85) return POS_W'($urandom_range(shadow_len + 1, 1));
    return POS_W'($urandom_range(511));
  endfunction

  function automatic logic [POS_W-1:0] pick_read_pos();
    if (shadow_len > 0 && $urandom_range(99) < 80) return POS_W'($urandom_range(shadow_len, 1));
    return POS_W'($urandom_range(511));
  endfunction

  // One random operation; grow favors inserts, otherwise deletes dominate
  task automatic random_op(input bit grow);
    int               r;
    logic [POS_W-1:0] any_pos;
    r       = $urandom_range(99);
    any_pos = POS_W'($urandom_range(511));
    if (r < (grow ? 50 : 15))      put_item(ole_pkg::OP_INSERT, pick_insert_pos(), pick_value());
    else if (r < (grow ? 60 : 55)) put_item(ole_pkg::OP_DELETE, pick_read_pos(), pick_value());
    else if (r < (grow ? 72 : 67)) put_item(ole_pkg::OP_GET, pick_read_pos(), pick_value());
    else if (r < (grow ? 84 : 80)) put_item(ole_pkg::OP_PRED, any_pos, pick_value());
    else if (r < (grow ? 96 : 93)) put_item(ole_pkg::OP_SUCC, any_pos, pick_value());
    else if (r < (grow ? 97 : 95)) put_item(ole_pkg::OP_CLEAR, any_pos, $urandom);
    else put_item($urandom_range(1) ? ole_pkg::OP_NONE : OP_SPARE, any_pos, $urandom);
  endtask

  // Random stretch keeping the list roughly between 20 and 80 entries
  task automatic random_run(input int count);
    repeat (count)
      random_op(shadow_len < 20 ? 1'b1 : (shadow_len > 80 ? 1'b0 : bit'($urandom_range(1))));
  endtask

  // Fill the list to capacity, work it while full, then empty it
  task automatic full_list_run();
    while (shadow_len < CAPACITY) put_item(ole_pkg::OP_INSERT, pick_insert_pos(), pick_value());
    put_item(ole_pkg::OP_INSERT, POS_W'(CAPACITY + 1), pick_value());   // valid slot, no room
    put_item(ole_pkg::OP_INSERT, 9'd1, pick_value());
    put_item(ole_pkg::OP_INSERT, POS_W'(CAPACITY + 2), pick_value());   // bad slot wins over full
    put_item(ole_pkg::OP_GET, POS_W'(CAPACITY), 32'd0);
    put_item(ole_pkg::OP_GET, POS_W'(CAPACITY + 1), 32'd0);
    put_item(ole_pkg::OP_DELETE, POS_W'(CAPACITY), 32'd0);
    put_item(ole_pkg::OP_INSERT, POS_W'(CAPACITY), pick_value());
    repeat (24) random_op(1'b1);
    put_item(ole_pkg::OP_CLEAR, 9'd0, 32'd0);
  endtask

  initial begin
    int guard;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, bounds, extremes, searches, spare opcodes, clear
    put_item(ole_pkg::OP_GET, 9'd1, 32'd0);
    put_item(ole_pkg::OP_DELETE, 9'd1, 32'd0);
    put_item(ole_pkg::OP_PRED, 9'd0, 32'd0);
    put_item(ole_pkg::OP_SUCC, 9'd0, 32'd0);
    put_item(ole_pkg::OP_INSERT, 9'd0, 32'd7);
    put_item(ole_pkg::OP_INSERT, 9'd2, 32'd7);
    put_item(ole_pkg::OP_INSERT, 9'd1, VAL_MAX);
    put_item(ole_pkg::OP_INSERT, 9'd1, VAL_MIN);
    put_item(ole_pkg::OP_INSERT, 9'd3, VAL_NEG1);
    put_item(ole_pkg::OP_INSERT, 9'd2, 32'd0);
    put_item(ole_pkg::OP_INSERT, 9'd5, 32'd0);
    put_item(ole_pkg::OP_INSERT, 9'd511, 32'd5);
    put_item(ole_pkg::OP_GET, 9'd1, 32'd0);
    put_item(ole_pkg::OP_GET, 9'd5, 32'd0);
    put_item(ole_pkg::OP_GET, 9'd6, 32'd0);
    put_item(ole_pkg::OP_GET, 9'd511, 32'd0);
    put_item(ole_pkg::OP_PRED, 9'd0, VAL_MIN);       // match at the head
    put_item(ole_pkg::OP_PRED, 9'd0, 32'd0);         // first of two matches
    put_item(ole_pkg::OP_SUCC, 9'd0, 32'd0);
    put_item(ole_pkg::OP_DELETE, 9'd5, 32'd0);
    put_item(ole_pkg::OP_SUCC, 9'd0, VAL_NEG1);      // match at the tail
    put_item(ole_pkg::OP_PRED, 9'd0, 32'd12345);     // no match
    put_item(OP_SPARE, 9'd511, VAL_NEG1);
    put_item(ole_pkg::OP_NONE, 9'd511, VAL_NEG1);
    put_item(ole_pkg::OP_DELETE, 9'd0, 32'd0);
    put_item(ole_pkg::OP_DELETE, 9'd1, 32'd0);
    put_item(ole_pkg::OP_CLEAR, 9'd0, 32'd0);
    put_item(ole_pkg::OP_GET, 9'd1, 32'd0);

    // Random: light sender, heavy receiver stalls
    random_run(250);
    // Swap the idle ratios; full list sequence runs here
    src_idle_pct = 46;
    snk_idle_pct = 26;
    full_list_run();
    random_run(130);
    // No idling on either side
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_run(230);
    s_tvalid <= 1'b0;

    // Drain, then give any stray reply time to show up
    for (guard = 0; guard < 50000 && waiting != 0; guard++) @(negedge clk);
    repeat (CAPACITY + 16) @(posedge clk);
    @(negedge clk);

    $display("Covered %0d list operations: %0d ok, %0d miss/bad position, %0d full replies.",
             sent_count, n_ok, n_miss, n_full);
    $display("List peaked at %0d entries; reply side held off once for %0d cycles.",
             peak_len, HOLD_CYCLES);
    if (fail_count == 0 && waiting == 0) begin
      $display("SUCCESS");
    end else begin
      if (waiting != 0) $error("%0d replies never arrived", waiting);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/ole_pkg.sv
hdl/ole_cell.sv
hdl/ole_ctrl.sv
hdl/ordered_list_engine.sv
hdl/ole_checker.sv
test/ole_checker.sv
test/tb_ordered_list_engine.sv
